/* rtl/gdf_pkg.sv */
// Shared types and constants of the grouped decimal formatter.
`timescale 1ns / 1ps

package gdf_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned SepLenW   = 3;
  localparam int unsigned SepCharsW = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitIdxW = $clog2(NumDigits);
  localparam int unsigned SepIdxW   = 2;
  localparam int unsigned GroupW    = 2;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [SepLenW-1:0]   SepLenMax        = 3'd4;
  localparam logic [SepLenW-1:0]   SepLenReset      = 3'd1;
  localparam logic [SepCharsW-1:0] SepCharsReset    = 32'd44;
  localparam logic [CharW-1:0]     MinusChar        = 8'h2D;
  localparam logic [CharW-1:0]     DigitZero        = 8'h30;
  localparam logic [GroupW-1:0]    GroupLastPhase   = 2'd2;

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    RegSepLength = 1'b0,
    RegSepChars  = 1'b1
  } gdf_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic emit_sign;
    logic emit_digit;
    logic emit_sep;
  } gdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic negative;
    logic digit_zero;
    logic sep_needed;
    logic sep_last;
    logic out_free;
  } gdf_status_t;

endpackage

/* rtl/grouped_decimal_formatter_top.sv */
// Top level of the grouped decimal formatter.
`timescale 1ns / 1ps
//
// The block turns one signed 32-bit integer per input item into its decimal
// text, one ASCII character per output item, most significant first, with a
// leading minus for negative values and the configured separator between
// groups of three digits. The final character of a value carries tlast.
// Input items arrive on the s_axis channel (tdata: value), characters leave
// on the m_axis channel (tdata: char_out, tlast: last). The two registers,
// separator length and separator characters, are written over the APB port.
// The user must write them only while the block is idle; the block itself
// does not enforce this. An accepted value first passes through a digit
// extraction loop that yields one decimal digit per cycle, D digits in all
// (1 to 10), using the divide-by-ten reciprocal multiplier. Characters are
// then produced one per cycle into an output register while the receiver
// accepts them. A value yields C characters (1 to 23). One value is handled
// at a time; s_axis_tready is high only between values. A stalled receiver
// holds the output item in place and the block waits. Reset restores a
// single comma separator and empties the output register.

module grouped_decimal_formatter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gdf_pkg::ValueW-1:0]       s_axis_tdata,   // [31:0] value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gdf_pkg::CharW-1:0]        m_axis_tdata,   // [7:0] char_out
  output logic                             m_axis_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gdf_pkg::ApbAddrW-1:0]     paddr,
  input  logic [gdf_pkg::ApbDataW-1:0]     pwdata,
  output logic [gdf_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready
);
  import gdf_pkg::*;

  gdf_cmd_t             cmd;
  gdf_status_t          status;
  logic [SepLenW-1:0]   sep_len;
  logic [SepCharsW-1:0] sep_chars;

  // Register file; the length it hands on is already saturated.
  gdf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sep_len_o   (sep_len),
    .sep_chars_o (sep_chars)
  );

  // The controller sequences extraction, then sign, digits and separators.
  gdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the magnitude, the digit store and the output register.
  gdf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (s_axis_tdata),
    .sep_len_i   (sep_len),
    .sep_chars_i (sep_chars),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* rtl/gdf_regs.sv */
// Configuration registers of the grouped decimal formatter behind an APB port.
`timescale 1ns / 1ps

module gdf_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gdf_pkg::ApbAddrW-1:0]     paddr,
  input  logic [gdf_pkg::ApbDataW-1:0]     pwdata,
  output logic [gdf_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready,
  output logic [gdf_pkg::SepLenW-1:0]      sep_len_o,
  output logic [gdf_pkg::SepCharsW-1:0]    sep_chars_o
);
  import gdf_pkg::*;

  logic [SepLenW-1:0]   sep_len_q,   sep_len_d;
  logic [SepCharsW-1:0] sep_chars_q, sep_chars_d;
  logic                 wr_en;
  gdf_reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = gdf_reg_e'(paddr[2]);

  always_comb begin
    sep_len_d   = sep_len_q;
    sep_chars_d = sep_chars_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegSepLength: sep_len_d   = pwdata[SepLenW-1:0];
        RegSepChars:  sep_chars_d = pwdata[SepCharsW-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_len_q   <= SepLenReset;
      sep_chars_q <= SepCharsReset;
    end else begin
      sep_len_q   <= sep_len_d;
      sep_chars_q <= sep_chars_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegSepLength: prdata = {{(ApbDataW-SepLenW){1'b0}}, sep_len_q};
      RegSepChars:  prdata = sep_chars_q;
      default:      prdata = '0;
    endcase
  end

  // Lengths above the maximum behave as the maximum.
  assign sep_len_o   = (sep_len_q > SepLenMax) ? SepLenMax : sep_len_q;
  assign sep_chars_o = sep_chars_q;

endmodule

/* rtl/gdf_datapath.sv */
// Datapath: digit extraction by reciprocal multiply, digit store and output register.
`timescale 1ns / 1ps

module gdf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gdf_pkg::gdf_cmd_t              cmd_i,
  output gdf_pkg::gdf_status_t           status_o,
  input  logic [gdf_pkg::ValueW-1:0]     value_i,
  input  logic [gdf_pkg::SepLenW-1:0]    sep_len_i,
  input  logic [gdf_pkg::SepCharsW-1:0]  sep_chars_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gdf_pkg::CharW-1:0]      out_char_o,
  output logic                           out_last_o
);
  import gdf_pkg::*;

  localparam logic [ValueW-1:0] RecipTen = 32'hCCCCCCCD;
  localparam int unsigned       RecipSh  = 35;

  logic [ValueW-1:0]    mag_q,   mag_d;
  logic                 neg_q,   neg_d;
  logic [DigitW-1:0]    digits_q [NumDigits];
  logic [DigitIdxW-1:0] didx_q,  didx_d;
  logic [GroupW-1:0]    grp_q,   grp_d;
  logic [SepIdxW-1:0]   sidx_q,  sidx_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharW-1:0]     out_char_q;
  logic                 out_last_q;

  logic [2*ValueW-1:0]  prod;
  logic [ValueW-1:0]    quot;
  logic [ValueW-1:0]    quot_x10;
  logic [DigitW-1:0]    rem;
  logic                 emit;
  logic [CharW-1:0]     emit_char;
  logic                 sep_last;

  // mag / 10 exactly for every 32-bit mag.
  assign prod     = {{ValueW{1'b0}}, mag_q} * {{ValueW{1'b0}}, RecipTen};
  assign quot     = {{RecipSh-ValueW{1'b0}}, prod[2*ValueW-1:RecipSh]};
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = mag_q[DigitW-1:0] - quot_x10[DigitW-1:0];

  assign sep_last = ({1'b0, sidx_q} == (sep_len_i - 3'd1));
  assign emit     = cmd_i.emit_sign | cmd_i.emit_digit | cmd_i.emit_sep;

  always_comb begin
    emit_char = MinusChar;
    if (cmd_i.emit_digit) begin
      emit_char = DigitZero + {{(CharW-DigitW){1'b0}}, digits_q[didx_q]};
    end else if (cmd_i.emit_sep) begin
      emit_char = sep_chars_i[{sidx_q, 3'b000} +: CharW];
    end
  end

  always_comb begin
    mag_d  = mag_q;
    neg_d  = neg_q;
    didx_d = didx_q;
    grp_d  = grp_q;
    sidx_d = sidx_q;
    if (cmd_i.load) begin
      neg_d  = value_i[ValueW-1];
      mag_d  = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      didx_d = '0;
      grp_d  = '0;
      sidx_d = '0;
    end else if (cmd_i.conv) begin
      mag_d = quot;
      if (quot != '0) begin
        didx_d = didx_q + DigitIdxW'(1);
        grp_d  = (grp_q == GroupLastPhase) ? '0 : grp_q + GroupW'(1);
      end
    end else if (cmd_i.emit_digit) begin
      if (didx_q != '0) begin
        didx_d = didx_q - DigitIdxW'(1);
        grp_d  = (grp_q == '0) ? GroupLastPhase : grp_q - GroupW'(1);
      end
    end else if (cmd_i.emit_sep) begin
      sidx_d = sep_last ? '0 : sidx_q + SepIdxW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      didx_q      <= '0;
      grp_q       <= '0;
      sidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      didx_q      <= didx_d;
      grp_q       <= grp_d;
      sidx_q      <= sidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    if (cmd_i.conv) begin
      digits_q[didx_q] <= rem;
    end
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= cmd_i.emit_digit & (didx_q == '0);
    end
  end

  assign status_o.conv_done  = (quot == '0);
  assign status_o.negative   = neg_q;
  assign status_o.digit_zero = (didx_q == '0);
  assign status_o.sep_needed = (grp_q == '0) && (sep_len_i != '0);
  assign status_o.sep_last   = sep_last;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/gdf_ctrl.sv */
// Controller state machine of the grouped decimal formatter.
`timescale 1ns / 1ps

module gdf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gdf_pkg::gdf_status_t  status_i,
  output gdf_pkg::gdf_cmd_t     cmd_o
);
  import gdf_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StConv  = 5'b00010,
    StSign  = 5'b00100,
    StDigit = 5'b01000,
    StSep   = 5'b10000
  } gdf_state_e;

  gdf_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (status_i.conv_done) begin
          state_d = status_i.negative ? StSign : StDigit;
        end
      end
      StSign: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StDigit;
        end
      end
      StDigit: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.digit_zero) begin
            state_d = StIdle;
          end else if (status_i.sep_needed) begin
            state_d = StSep;
          end
        end
      end
      StSep: begin
        if (status_i.out_free) begin
          cmd_o.emit_sep = 1'b1;
          if (status_i.sep_last) begin
            state_d = StDigit;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/gdf_checker.sv */
// Port-level checks of the grouped decimal formatter and their bind.
`timescale 1ns / 1ps

module gdf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [gdf_pkg::CharW-1:0]    m_axis_tdata,
  input logic                         m_axis_tlast
);

  // A stalled output item stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  // One value at a time: no new item right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again before the text was produced");

  // Between values, only the final character of the previous text may wait.
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("block idle with an unfinished text pending");

  // Right after acceptance, nothing of the new text is out yet.
  a_no_early_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || m_axis_tlast)
    else $error("character of a new value appeared too early");

endmodule

bind grouped_decimal_formatter_top gdf_checker u_gdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
